[hdl/sorted_set_k_select_unit_defines.svh]
// Assertion macros for the sorted set k-select unit.
// Used by the port-level checker; depends on nothing else.
`ifndef SORTED_SET_K_SELECT_UNIT_DEFINES_SVH
`define SORTED_SET_K_SELECT_UNIT_DEFINES_SVH

// condition holds in the same cycle
`define SKS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define SKS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sks_pkg.sv]
// Shared widths, codes and types of the sorted set k-select unit.
// Used by the channel interfaces, the cell row, the top level and the checker.
package sks_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned K_W      = 7;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_ASC    = 2'd1,
    CMD_DESC   = 2'd2,
    CMD_NONE   = 2'd3
  } sks_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_ELEM     = 3'd3,
    ST_SHORT    = 3'd4,
    ST_EMPTY    = 3'd5
  } sks_status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROT_L,
    OP_ROT_R
  } sks_op_e;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } sks_state_e;

  typedef struct packed {
    sks_op_e                  op;
    logic signed [DATA_W-1:0] value;
  } sks_ctl_t;

endpackage

[hdl/sks_chan_if.sv]
// Valid/ready channel interfaces for the item and result beats.
// Depends on sks_pkg for field widths.
interface sks_in_if import sks_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] value;
  logic [K_W-1:0]           k;

  modport source (output valid, cmd, value, k, input ready);
  modport sink   (input valid, cmd, value, k, output ready);
endinterface

interface sks_out_if import sks_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] element;
  logic [STATUS_W-1:0]      status;
  logic                     last;

  modport source (output valid, element, status, last, input ready);
  modport sink   (input valid, element, status, last, output ready);
endinterface

[hdl/sks_cell.sv]
// One cell of the sorted row: holds a value, compares it with the insert
// value and takes its neighbour's value on a shift. Depends on sks_pkg.
module sks_cell import sks_pkg::*; (
  input  logic                     clk_i,
  input  sks_ctl_t                 ctl_i,
  input  logic                     occ_i,
  input  logic signed [DATA_W-1:0] left_val_i,
  input  logic                     left_ins_i,
  input  logic signed [DATA_W-1:0] right_val_i,
  output logic signed [DATA_W-1:0] val_o,
  output logic                     ins_o,
  output logic                     dup_o
);

  logic signed [DATA_W-1:0] val_q, val_d;

  assign val_o = val_q;
  assign ins_o = !occ_i || (val_q > ctl_i.value);
  assign dup_o = occ_i && (val_q == ctl_i.value);

  always_comb begin
    val_d = val_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (ins_o) begin
          val_d = left_ins_i ? left_val_i : ctl_i.value;
        end
      end
      OP_ROT_L: val_d = right_val_i;
      OP_ROT_R: val_d = left_val_i;
      default:  val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

[hdl/sks_row.sv]
// Ring of sorted cells with the duplicate flag gathered over the row.
// Depends on sks_pkg and sks_cell.
module sks_row import sks_pkg::*; (
  input  logic                     clk_i,
  input  sks_ctl_t                 ctl_i,
  input  logic [CNT_W-1:0]         count_i,
  output logic                     dup_o,
  output logic signed [DATA_W-1:0] head_o,
  output logic signed [DATA_W-1:0] tail_o
);

  logic signed [DATA_W-1:0] val [CAPACITY];
  logic [CAPACITY-1:0]      ins;
  logic [CAPACITY-1:0]      dup;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int unsigned LEFT  = (i + CAPACITY - 1) % CAPACITY;
    localparam int unsigned RIGHT = (i + 1) % CAPACITY;

    sks_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl_i),
      .occ_i       (CNT_W'(i) < count_i),
      .left_val_i  (val[LEFT]),
      .left_ins_i  ((i == 0) ? 1'b0 : ins[LEFT]),
      .right_val_i (val[RIGHT]),
      .val_o       (val[i]),
      .ins_o       (ins[i]),
      .dup_o       (dup[i])
    );
  end

  assign dup_o  = |dup;
  assign head_o = val[0];
  assign tail_o = val[CAPACITY-1];

endmodule

[hdl/sorted_set_k_select_unit.sv]
// Sorted set of distinct signed values with k-smallest / k-largest listing.
// Depends on sks_pkg, the channel interfaces and sks_row.
//
// Item channel in_i (sink): cmd, value, k. Result channel out_o (source):
// element, status, last. A beat moves when valid and ready are both high.
// On an insert the row compares every cell with the value in parallel and
// shifts the larger ones right by one; its single result is registered and
// shown the cycle after the beat. An unused command is taken and dropped.
// A query on an empty set or with k of zero answers with one empty result,
// also the next cycle. Any other query rotates the ring of cells once round,
// one position a cycle unless a stall holds it: the smallest-first list is
// read from the first cell while rotating left from the cycle after the
// beat, the largest-first list from the last cell while rotating right,
// starting once the largest element has reached that cell. Results then
// come one a cycle unless the receiver stalls. A new item is taken only
// after the ring has gone once round. A stall at the receiver holds the
// result register, and the rotation too while a list element is due. Items
// are refused while the result register is full and not being drained.
// Reset empties the set and clears the result valid flag; the cells need no
// clearing, as only cells below the count are ever read.
module sorted_set_k_select_unit import sks_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  sks_in_if.sink    in_i,
  sks_out_if.source out_o
);

  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CAPACITY - 1);

  sks_state_e               state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [IDX_W-1:0]         step_q, step_d;
  logic [CNT_W-1:0]         emitted_q, emitted_d;
  logic [CNT_W-1:0]         emit_q, emit_d;
  logic                     desc_q, desc_d;
  logic                     short_q, short_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_elem_q, out_elem_d;
  logic [STATUS_W-1:0]      out_status_q, out_status_d;
  logic                     out_last_q, out_last_d;

  sks_ctl_t                 ctl;
  logic                     dup_any;
  logic signed [DATA_W-1:0] head, tail;
  logic                     out_free;
  logic                     in_ready;
  logic                     in_window;
  logic                     emit_now;

  sks_row u_row (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .count_i (count_q),
    .dup_o   (dup_any),
    .head_o  (head),
    .tail_o  (tail)
  );

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_ready  = (state_q == S_IDLE) && out_free;
  assign in_window = !desc_q ||
                     (({1'b0, CNT_W'(step_q)} + {1'b0, count_q}) >= (CNT_W + 1)'(CAPACITY));
  assign emit_now  = (state_q == S_LIST) && in_window && (emitted_q < emit_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    step_d       = step_q;
    emitted_d    = emitted_q;
    emit_d       = emit_q;
    desc_d       = desc_q;
    short_d      = short_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_elem_d   = out_elem_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    ctl.op       = OP_HOLD;
    ctl.value    = in_i.value;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid && in_ready) begin
          case (sks_cmd_e'(in_i.cmd))
            CMD_INSERT: begin
              out_valid_d = 1'b1;
              out_elem_d  = '0;
              out_last_d  = 1'b1;
              if (dup_any) begin
                out_status_d = ST_DUP;
              end else if (count_q == CNT_W'(CAPACITY)) begin
                out_status_d = ST_FULL;
              end else begin
                out_status_d = ST_INSERTED;
                ctl.op       = OP_INSERT;
                count_d      = count_q + CNT_W'(1);
              end
            end
            CMD_ASC, CMD_DESC: begin
              if (count_q == '0 || in_i.k == '0) begin
                out_valid_d  = 1'b1;
                out_elem_d   = '0;
                out_status_d = ST_EMPTY;
                out_last_d   = 1'b1;
              end else begin
                if (in_i.k > K_W'(count_q)) begin
                  emit_d  = count_q;
                  short_d = 1'b1;
                end else begin
                  emit_d  = CNT_W'(in_i.k);
                  short_d = 1'b0;
                end
                desc_d    = (sks_cmd_e'(in_i.cmd) == CMD_DESC);
                step_d    = '0;
                emitted_d = '0;
                state_d   = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        if (!emit_now || out_free) begin
          if (emit_now) begin
            out_valid_d  = 1'b1;
            out_elem_d   = desc_q ? tail : head;
            out_status_d = short_q ? ST_SHORT : ST_ELEM;
            out_last_d   = (emitted_q + CNT_W'(1) == emit_q);
            emitted_d    = emitted_q + CNT_W'(1);
          end
          ctl.op = desc_q ? OP_ROT_R : OP_ROT_L;
          if (step_q == LAST_STEP) begin
            step_d  = '0;
            state_d = S_IDLE;
          end else begin
            step_d = step_q + IDX_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      emitted_q   <= '0;
      emit_q      <= '0;
      desc_q      <= 1'b0;
      short_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      emitted_q   <= emitted_d;
      emit_q      <= emit_d;
      desc_q      <= desc_d;
      short_q     <= short_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_elem_q   <= out_elem_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.element = out_elem_q;
  assign out_o.status  = out_status_q;
  assign out_o.last    = out_last_q;

endmodule

[hdl/sks_checker.sv]
// Port-level checks of the sorted set k-select unit, bound to its top level.
// Depends on sks_pkg and sorted_set_k_select_unit_defines.svh.
`include "sorted_set_k_select_unit_defines.svh"

module sks_checker import sks_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic [CMD_W-1:0]    in_cmd_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] out_status_i,
  input logic                out_last_i
);

  `SKS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_status_i) && $stable(out_last_i), "result beat dropped while stalled")
  `SKS_ASSERT_NXT(a_insert_answer, clk_i, rst_ni, in_valid_i && in_ready_i && in_cmd_i == CMD_INSERT, out_valid_i && out_last_i && (out_status_i == ST_INSERTED || out_status_i == ST_DUP || out_status_i == ST_FULL), "insert beat without its single result")
  `SKS_ASSERT_IMP(a_list_blocks, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i, "item taken in the middle of a list")
  `SKS_ASSERT_IMP(a_list_status, clk_i, rst_ni, out_valid_i && !out_last_i, out_status_i == ST_ELEM || out_status_i == ST_SHORT, "non-final result that is not a list element")

endmodule

bind sorted_set_k_select_unit sks_checker u_sks_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_cmd_i     (in_i.cmd),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_last_i   (out_o.last)
);

[dv/sorted_set_k_select_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for sorted_set_k_select_unit: directed and random inserts and
// k-smallest / k-largest queries, with every result beat checked against a predicted set.
// Depends on sks_pkg, the channel interfaces and the unit itself.
module sorted_set_k_select_unit_tb;
  import sks_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] element;
    sks_status_e              status;
    logic                     last;
  } result_beat_t;

  class kselect_scoreboard;
    logic signed [DATA_W-1:0] set_row [CAPACITY];
    int                       set_size = 0;
    result_beat_t             predicted_beats [$];
    int                       errors = 0;

    function void predict_beat(logic signed [DATA_W-1:0] element, sks_status_e status,
                               logic last);
      result_beat_t beat;
      beat.element = element;
      beat.status  = status;
      beat.last    = last;
      predicted_beats.push_back(beat);
    endfunction

    function sks_status_e insert_value(logic signed [DATA_W-1:0] value);
      int pos;
      pos = 0;
      while (pos < set_size && set_row[pos] < value) pos++;
      if (pos < set_size && set_row[pos] == value) return ST_DUP;
      if (set_size >= CAPACITY) return ST_FULL;
      for (int i = set_size; i > pos; i--) set_row[i] = set_row[i-1];
      set_row[pos] = value;
      set_size++;
      return ST_INSERTED;
    endfunction

    function void note_item(sks_cmd_e cmd, logic signed [DATA_W-1:0] value,
                            logic [K_W-1:0] k);
      int          emit;
      sks_status_e status;
      case (cmd)
        CMD_INSERT: predict_beat('0, insert_value(value), 1'b1);
        CMD_ASC, CMD_DESC: begin
          if (set_size == 0 || k == 0) begin
            predict_beat('0, ST_EMPTY, 1'b1);
          end else begin
            if (int'(k) > set_size) begin
              emit   = set_size;
              status = ST_SHORT;
            end else begin
              emit   = int'(k);
              status = ST_ELEM;
            end
            for (int i = 0; i < emit; i++)
              predict_beat((cmd == CMD_ASC) ? set_row[i] : set_row[set_size-1-i], status,
                           i == emit - 1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [DATA_W-1:0] element, logic [STATUS_W-1:0] status,
                               logic last);
      result_beat_t want;
      if (predicted_beats.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unpredicted result element=%0d status=%0d last=%0b",
                   $realtime, element, status, last);
        return;
      end
      want = predicted_beats.pop_front();
      if (element !== want.element || status !== want.status || last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch expected element=%0d status=%0d last=%0b, got %0d %0d %0b",
                   $realtime, want.element, want.status, want.last, element, status, last);
      end
    endfunction

    function void close_out();
      if (predicted_beats.size() != 0) begin
        errors++;
        $display("%0d predicted results never arrived", predicted_beats.size());
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sks_in_if  in_if ();
  sks_out_if out_if ();

  sorted_set_k_select_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  kselect_scoreboard sb;
  int burst_left = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.element, out_if.status, out_if.last);
  end

  initial begin : receiver_stalls
    int mode;
    int span;
    int phase;
    out_if.ready = 1'b0;
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(negedge clk);
        phase++;
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= ($urandom_range(0, 99) < 70);
          2:       out_if.ready <= (phase % 3 != 0);
          default: out_if.ready <= ($urandom_range(0, 99) < 30);
        endcase
      end
    end
  end

  task automatic send_item(sks_cmd_e cmd, logic signed [DATA_W-1:0] value,
                           logic [K_W-1:0] k);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = 30;
      end else begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 8);
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.value <= value;
    in_if.k     <= k;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(cmd, value, k);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.predicted_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 40) - 20;
      3:       return ($urandom_range(0, 1) == 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      4:       if (sb.set_size > 0) return sb.set_row[$urandom_range(0, sb.set_size - 1)];
               else return $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [K_W-1:0] pick_k();
    int near;
    case ($urandom_range(0, 3))
      0:       return K_W'($urandom_range(0, 127));
      1:       return K_W'($urandom_range(0, 4));
      2: begin
        near = sb.set_size + $urandom_range(0, 2) - 1;
        return (near < 0) ? '0 : K_W'(near);
      end
      default: return K_W'($urandom_range(0, sb.set_size));
    endcase
  endfunction

  initial begin : stimulus
    int roll;
    int post_full;
    sb = new;
    rst_n       = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd   = CMD_INSERT;
    in_if.value = '0;
    in_if.k     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty set, k of zero, unused command
    send_item(CMD_ASC, 0, 5);
    send_item(CMD_DESC, 0, 0);
    send_item(CMD_NONE, $urandom, K_W'($urandom_range(0, 127)));
    // extremes and duplicates
    send_item(CMD_INSERT, 0, 0);
    send_item(CMD_INSERT, 32'sh8000_0000, 0);
    send_item(CMD_INSERT, 32'sh7fff_ffff, 0);
    send_item(CMD_INSERT, -1, 0);
    send_item(CMD_INSERT, 1, 0);
    send_item(CMD_INSERT, 0, 0);
    send_item(CMD_INSERT, 32'sh7fff_ffff, 0);
    // full lists, short lists, k of zero on a populated set
    send_item(CMD_ASC, 0, 0);
    send_item(CMD_ASC, 0, 1);
    send_item(CMD_DESC, 0, 3);
    send_item(CMD_ASC, 0, 5);
    send_item(CMD_DESC, 0, 6);
    send_item(CMD_ASC, 0, 127);
    send_item(CMD_DESC, 0, 64);
    send_item(CMD_NONE, 0, 0);
    send_item(CMD_INSERT, 32'sh5555_5555, 0);
    send_item(CMD_INSERT, 32'shaaaa_aaaa, 0);
    send_item(CMD_ASC, 0, 7);

    post_full = 0;
    for (int n = 0; n < 110 && (n < 85 || post_full < 10); n++) begin
      if (n == 55) drain_results();
      if (sb.set_size == CAPACITY) post_full++;
      roll = $urandom_range(0, 99);
      if (roll < 5)
        send_item(CMD_NONE, $urandom, K_W'($urandom_range(0, 127)));
      else if (roll < ((sb.set_size < CAPACITY) ? 72 : 40))
        send_item(CMD_INSERT, pick_value(), K_W'($urandom_range(0, 127)));
      else
        send_item(($urandom_range(0, 1) == 1) ? CMD_ASC : CMD_DESC, $urandom, pick_k());
    end

    // hold off until the last beat, then let the ring settle
    drain_results();
    repeat (3 * CAPACITY) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
